FILE: sv/bzs_pkg.sv
// Shared types, constants and the fixed-point lerp for the Bezier splat core.
// Depends on nothing; the design files and the checker use it by scoped names.
package bzs_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;
	localparam int NUM_CFG      = 8;
	localparam int COORD_W      = 10;
	localparam int Q_W          = 26;
	localparam logic [16:0] T_ONE = 17'h10000;
	localparam logic [15:0] FULL_SQ = 16'd65025;
	localparam logic [7:0] FULL_SCALE = 8'd255;

	typedef struct packed {
		logic [3:0][COORD_W-1:0] x;
		logic [3:0][COORD_W-1:0] y;
	} ctrl_pts_t;

	typedef struct packed {
		logic [Q_W-1:0] qx;
		logic [Q_W-1:0] qy;
	} point_t;

	typedef struct packed {
		logic signed [11:0] px;
		logic signed [11:0] py;
		logic               on;
		logic               last;
		logic               zero;
	} pix_meta_t;

	typedef struct packed {
		pix_meta_t   meta;
		logic [15:0] ax;
		logic [15:0] ay;
	} pix_t;

	typedef struct packed {
		pix_meta_t   meta;
		logic [15:0] w;
		logic [7:0]  r;
	} root_t;

	// a + floor((b - a) * t / 2^16), equal to (a*(1-t) + b*t) >> 16.
	function automatic logic [Q_W-1:0] lerp(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b,
			input logic [16:0] t);
		logic signed [Q_W:0]    diff;
		logic signed [Q_W+18:0] prod;
		logic signed [Q_W+18:0] sum;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = diff * $signed({1'b0, t});
		sum  = (Q_W+19)'($signed({1'b0, a})) + (prod >>> 16);
		return sum[Q_W-1:0];
	endfunction

endpackage

FILE: sv/bzs_point.sv
// Three-stage de Casteljau evaluation of the cubic Bezier point in Q.16.
// Depends on bzs_pkg.
module bzs_point (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [16:0]        t,
	input  bzs_pkg::ctrl_pts_t pts,
	output logic               out_valid,
	output bzs_pkg::point_t    point
);

	logic [16:0] t_sat;
	logic [16:0] t_s1, t_s2;
	logic        v_s1, v_s2, v_s3;
	logic [2:0][bzs_pkg::Q_W-1:0] lx_s1, ly_s1;
	logic [1:0][bzs_pkg::Q_W-1:0] mx_s2, my_s2;
	bzs_pkg::point_t p_s3;

	assign t_sat = (t > bzs_pkg::T_ONE) ? bzs_pkg::T_ONE : t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_sat;
		for (int i = 0; i < 3; i++) begin
			lx_s1[i] <= bzs_pkg::lerp({pts.x[i], 16'b0}, {pts.x[i+1], 16'b0}, t_sat);
			ly_s1[i] <= bzs_pkg::lerp({pts.y[i], 16'b0}, {pts.y[i+1], 16'b0}, t_sat);
		end
		t_s2 <= t_s1;
		for (int i = 0; i < 2; i++) begin
			mx_s2[i] <= bzs_pkg::lerp(lx_s1[i], lx_s1[i+1], t_s1);
			my_s2[i] <= bzs_pkg::lerp(ly_s1[i], ly_s1[i+1], t_s1);
		end
		p_s3.qx <= bzs_pkg::lerp(mx_s2[0], mx_s2[1], t_s2);
		p_s3.qy <= bzs_pkg::lerp(my_s2[0], my_s2[1], t_s2);
	end

	assign out_valid = v_s3;
	assign point     = p_s3;

endmodule

FILE: sv/bzs_emit.sv
// Walks the 3x3 pixel block around one point, one pixel per cycle.
// Depends on bzs_pkg.
module bzs_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  bzs_pkg::point_t point,
	output logic            pix_valid,
	output bzs_pkg::pix_t   pix
);

	logic        act_q;
	logic [1:0]  col_q, row_q;
	bzs_pkg::point_t pt_q;
	logic        last;
	logic signed [11:0] px, py;
	logic        on_x, on_y, zx, zy;
	logic [15:0] fx, fy;

	assign last = (col_q == 2'd2) && (row_q == 2'd2);
	assign fx   = pt_q.qx[15:0];
	assign fy   = pt_q.qy[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			col_q <= 2'd0;
			row_q <= 2'd0;
		end else if (in_valid) begin
			act_q <= 1'b1;
			col_q <= 2'd0;
			row_q <= 2'd0;
		end else if (act_q) begin
			if (last) begin
				act_q <= 1'b0;
			end
			if (col_q == 2'd2) begin
				col_q <= 2'd0;
				row_q <= row_q + 2'd1;
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			pt_q <= point;
		end
	end

	assign px = $signed({2'b0, pt_q.qx[25:16]}) - 12'sd1 + $signed({10'b0, col_q});
	assign py = $signed({2'b0, pt_q.qy[25:16]}) - 12'sd1 + $signed({10'b0, row_q});

	assign on_x = !px[11] && ({1'b0, px} < 13'(bzs_pkg::IMAGE_WIDTH));
	assign on_y = !py[11] && ({1'b0, py} < 13'(bzs_pkg::IMAGE_HEIGHT));

	// The left column and top row are always a full pixel or more away.
	assign zx = (col_q == 2'd0) || ((col_q == 2'd2) && (fx == 16'd0));
	assign zy = (row_q == 2'd0) || ((row_q == 2'd2) && (fy == 16'd0));

	always_comb begin
		pix.meta.px   = px;
		pix.meta.py   = py;
		pix.meta.on   = on_x && on_y;
		pix.meta.last = last;
		pix.meta.zero = zx || zy || !(on_x && on_y);
		pix.ax = (col_q == 2'd1) ? fx : 16'(17'h10000 - {1'b0, fx});
		pix.ay = (row_q == 2'd1) ? fy : 16'(17'h10000 - {1'b0, fy});
	end

	assign pix_valid = act_q;

endmodule

FILE: sv/bzs_cover.sv
// Pixel pipeline: squared distance, scaling, bitwise root and coverage.
// Depends on bzs_pkg.
module bzs_cover (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	input  bzs_pkg::pix_t pix,
	output logic          result_valid,
	output logic signed [11:0] pixel_x,
	output logic signed [11:0] pixel_y,
	output logic          on_image,
	output logic [7:0]    coverage,
	output logic          last
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_q;
	bzs_pkg::pix_t     p_s1;
	bzs_pkg::pix_meta_t m_s2, m_s3, m_s4;
	logic [31:0] sqx_s2, sqy_s2;
	logic [32:0] d2_s3;
	logic [47:0] v48_s4;
	logic [7:0]  rv_s;
	bzs_pkg::root_t rt_s [9];
	logic [7:0]  k;
	logic signed [11:0] px_q, py_q;
	logic        on_q, last_q;
	logic [7:0]  cov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			rv_s <= '0;
			v_q  <= 1'b0;
		end else begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			rv_s <= {rv_s[6:0], v_s5};
			v_q  <= rv_s[7];
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= pix;
		m_s2   <= p_s1.meta;
		sqx_s2 <= p_s1.ax * p_s1.ax;
		sqy_s2 <= p_s1.ay * p_s1.ay;
		m_s3   <= m_s2;
		d2_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		m_s4   <= {m_s3.px, m_s3.py, m_s3.on, m_s3.last, m_s3.zero || d2_s3[32]};
		v48_s4 <= 48'(d2_s3[31:0]) * 48'(bzs_pkg::FULL_SQ);
		// Ceiling of the scaled squared distance in whole units.
		rt_s[0].meta <= m_s4;
		rt_s[0].w    <= 16'(v48_s4[47:32] + 16'(v48_s4[31:0] != 32'd0));
		rt_s[0].r    <= 8'd0;
	end

	for (genvar b = 0; b < 8; b++) begin : g_root
		logic [7:0]  trial;
		logic [15:0] tsq;
		assign trial = rt_s[b].r | (8'd1 << (7 - b));
		assign tsq   = trial * trial;
		always_ff @(posedge clk) begin
			rt_s[b+1].meta <= rt_s[b].meta;
			rt_s[b+1].w    <= rt_s[b].w;
			rt_s[b+1].r    <= (tsq <= rt_s[b].w) ? trial : rt_s[b].r;
		end
	end

	// Smallest k with k*k >= w: the floor root, plus one unless exact.
	assign k = rt_s[8].r + 8'(16'(rt_s[8].r * rt_s[8].r) != rt_s[8].w);

	always_ff @(posedge clk) begin
		px_q   <= rt_s[8].meta.px;
		py_q   <= rt_s[8].meta.py;
		on_q   <= rt_s[8].meta.on;
		last_q <= rt_s[8].meta.last;
		cov_q  <= rt_s[8].meta.zero ? 8'd0 : bzs_pkg::FULL_SCALE - k;
	end

	assign result_valid = v_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign on_image     = on_q;
	assign coverage     = cov_q;
	assign last         = last_q;

endmodule

FILE: sv/bezier_antialiased_splat_core.sv
// Top level of the antialiased cubic Bezier splat core.
// Depends on bzs_pkg, bzs_point, bzs_emit and bzs_cover.

// A start beat carries one curve parameter t (Q1.16, values above 1.0 are
// clamped to 1.0). The core evaluates the Bezier point of the eight configured
// control coordinates and then sends nine result beats, one per pixel of the
// 3x3 block around the point, rows top to bottom and columns left to right,
// with last set on the ninth. Results appear on result_valid for exactly one
// cycle each and cannot be held off, so the receiver must take every beat.
// Busy holds off starts after each accepted one, spacing items so that the
// walker ends its nine pixels first, as the single result channel carries one
// pixel a cycle. An item passes three stages of curve evaluation, the block
// walker and a fourteen-stage distance and root pipeline, and successive items
// overlap in the pipeline.
// Configuration writes are always ready; indices beyond seven are ignored.
// Write configuration only while no item is in flight.
module bezier_antialiased_splat_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] t,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	output logic        result_valid,
	output logic signed [11:0] pixel_x,
	output logic signed [11:0] pixel_y,
	output logic        on_image,
	output logic [7:0]  coverage,
	output logic        last
);

	logic [bzs_pkg::NUM_CFG-1:0][bzs_pkg::COORD_W-1:0] cfg_q;
	bzs_pkg::ctrl_pts_t pts;
	logic [3:0]  gap_q;
	logic        accept;
	logic        pt_valid;
	bzs_pkg::point_t point;
	logic        pix_valid;
	bzs_pkg::pix_t pix;

	assign cfg_ready = 1'b1;

	// Control point registers; even indices are x, odd indices are y.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && (cfg_index < 4'(bzs_pkg::NUM_CFG))) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pts.x[i] = cfg_q[2*i];
			pts.y[i] = cfg_q[2*i+1];
		end
	end

	// Spacing counter: busy holds off starts after each accepted one, keeping the walker free.
	assign accept = start && !busy;
	assign busy   = (gap_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 4'd0;
		end else if (accept) begin
			gap_q <= 4'd8;
		end else if (busy) begin
			gap_q <= gap_q - 4'd1;
		end
	end

	bzs_point u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.t         (t),
		.pts       (pts),
		.out_valid (pt_valid),
		.point     (point)
	);

	bzs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pt_valid),
		.point     (point),
		.pix_valid (pix_valid),
		.pix       (pix)
	);

	bzs_cover u_cover (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix          (pix),
		.result_valid (result_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.on_image     (on_image),
		.coverage     (coverage),
		.last         (last)
	);

endmodule

FILE: tb/bzs_splat_checker.sv
// Checker for the Bezier splat core: predicts the nine pixel beats of every accepted t.
// Depends on bzs_pkg for the image size, register count and T_ONE.
`timescale 1ns / 100ps

module bzs_splat_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [16:0]        t,
	input  logic               busy,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	input  logic               result_valid,
	input  logic signed [11:0] pixel_x,
	input  logic signed [11:0] pixel_y,
	input  logic               on_image,
	input  logic [7:0]         coverage,
	input  logic               last,
	output int                 errors,
	output int                 pending,
	output int                 results_seen
);

	typedef struct {
		logic signed [11:0] px;
		logic signed [11:0] py;
		logic               on;
		logic [7:0]         cov;
		logic               last;
	} pixel_beat_t;

	pixel_beat_t splat_q[$];
	logic [9:0] pts_x[4];
	logic [9:0] pts_y[4];

	function automatic longint unsigned mix_q16(input longint unsigned a,
			input longint unsigned b, input longint unsigned tt);
		return (a * (64'd65536 - tt) + b * tt) >> 16;
	endfunction

	function automatic longint unsigned curve_q16(input logic [9:0] c[4],
			input longint unsigned tt);
		longint unsigned a, b, c2, d, ab, bc, cd;
		a  = longint'(c[0]) << 16;
		b  = longint'(c[1]) << 16;
		c2 = longint'(c[2]) << 16;
		d  = longint'(c[3]) << 16;
		ab = mix_q16(a, b, tt);
		bc = mix_q16(b, c2, tt);
		cd = mix_q16(c2, d, tt);
		return mix_q16(mix_q16(ab, bc, tt), mix_q16(bc, cd, tt), tt);
	endfunction

	// Largest c with 255^2 * d^2 <= (255-c)^2, where d2 is in Q.32.
	function automatic logic [7:0] coverage_of(input longint unsigned d2);
		longint unsigned lhs;
		if (d2 >= (64'd1 << 32))
			return 8'd0;
		lhs = 64'd65025 * d2;
		for (int k = 0; k <= 255; k++)
			if (lhs <= ((longint'(k) * k) << 32))
				return 8'(255 - k);
		return 8'd0;
	endfunction

	task automatic predict_splat(input logic [16:0] tin);
		longint unsigned tt, qx, qy;
		longint bx, by, px, py, dx, dy;
		pixel_beat_t b;
		tt = (tin > bzs_pkg::T_ONE) ? 64'd65536 : longint'(tin);
		qx = curve_q16(pts_x, tt);
		qy = curve_q16(pts_y, tt);
		bx = longint'(qx >> 16) - 1;
		by = longint'(qy >> 16) - 1;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				px = bx + j;
				py = by + i;
				dx = longint'(qx) - px * 65536;
				dy = longint'(qy) - py * 65536;
				b.px = 12'(px);
				b.py = 12'(py);
				b.on = px >= 0 && py >= 0 && px < bzs_pkg::IMAGE_WIDTH
					&& py < bzs_pkg::IMAGE_HEIGHT;
				b.cov = b.on ? coverage_of(longint'(dx * dx + dy * dy)) : 8'd0;
				b.last = (i == 2 && j == 2);
				splat_q = {splat_q, b};
			end
	endtask

	assign pending = splat_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_beat_t e;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pts_x[i] = '0;
				pts_y[i] = '0;
			end
			splat_q.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			// Register index 2k is x of point k, 2k+1 its y; higher indices are dropped.
			if (cfg_valid && cfg_ready && cfg_index < bzs_pkg::NUM_CFG) begin
				if (cfg_index[0])
					pts_y[cfg_index[2:1]] = cfg_data;
				else
					pts_x[cfg_index[2:1]] = cfg_data;
			end
			if (result_valid) begin
				results_seen++;
				if (splat_q.size() == 0) begin
					$error("pixel beat with nothing expected: x=%0d y=%0d", pixel_x, pixel_y);
					errors++;
				end else begin
					e = splat_q.pop_front();
					if (pixel_x !== e.px) begin
						$error("pixel_x: expected %0d, got %0d", e.px, pixel_x);
						errors++;
					end
					if (pixel_y !== e.py) begin
						$error("pixel_y: expected %0d, got %0d", e.py, pixel_y);
						errors++;
					end
					if (on_image !== e.on) begin
						$error("on_image: expected %0d, got %0d", e.on, on_image);
						errors++;
					end
					if (coverage !== e.cov) begin
						$error("coverage: expected %0d, got %0d", e.cov, coverage);
						errors++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						errors++;
					end
				end
			end
			if (start && !busy)
				predict_splat(t);
		end
	end

endmodule

FILE: tb/tb_bezier_antialiased_splat_core.sv
// Top of the Bezier splat testbench: clock, reset, control point and t stimulus, verdict.
// Depends on the core and bzs_splat_checker.
`timescale 1ns / 100ps

module tb_bezier_antialiased_splat_core;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic [16:0]        t;
	logic               busy;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_index;
	logic [9:0]         cfg_data;
	logic               result_valid;
	logic signed [11:0] pixel_x;
	logic signed [11:0] pixel_y;
	logic               on_image;
	logic [7:0]         coverage;
	logic               last;
	int                 errors;
	int                 pending;
	int                 results_seen;
	int                 items_sent;
	int                 phases;

	bezier_antialiased_splat_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .t(t), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .pixel_x(pixel_x),
		.pixel_y(pixel_y), .on_image(on_image), .coverage(coverage), .last(last)
	);

	// The checker sees exactly the same pins and keeps the only copy of the expectations.
	bzs_splat_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .t(t), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .pixel_x(pixel_x),
		.pixel_y(pixel_y), .on_image(on_image), .coverage(coverage), .last(last),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the core hangs or drops beats.
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly short gaps, now and then a long one, and often none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// One t beat. Start stays high while the core is busy; it drops only when a gap
	// follows, so back-to-back beats never see start lowered and raised in one step.
	task automatic send_t(input logic [16:0] v, input int gap);
		start <= 1'b1;
		t     <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Valid stays high between back-to-back writes; the caller lowers it after the last one.
	task automatic write_reg(input logic [3:0] idx, input logic [9:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Lets every predicted beat come home, then a short margin, before touching registers.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_points(input logic [9:0] x0, y0, x1, y1, x2, y2, x3, y3);
		drain();
		write_reg(4'd0, x0);
		write_reg(4'd1, y0);
		write_reg(4'd2, x1);
		write_reg(4'd3, y1);
		write_reg(4'd4, x2);
		write_reg(4'd5, y2);
		write_reg(4'd6, x3);
		write_reg(4'd7, y3);
		cfg_valid <= 1'b0;
		phases++;
	endtask

	// Coordinates cluster at the image edges so that off-image pixels show up often.
	function automatic logic [9:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 10'd0;
			1: return 10'd1023;
			2: return 10'($urandom_range(0, 2));
			3: return 10'($urandom_range(1021, 1023));
			default: return 10'($urandom());
		endcase
	endfunction

	function automatic logic [16:0] pick_t();
		case ($urandom_range(0, 9))
			0: return 17'h00000;
			1: return 17'h10000;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		t         = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		items_sent = 0;
		phases     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset points: everything at the origin, so the block straddles the top-left corner.
		send_t(17'h00000, 0);
		send_t(17'h1FFFF, 2);

		// All points at the far corner: the third row and column fall off the image.
		load_points(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
			10'd1023, 10'd1023);
		send_t(17'h08000, 0);
		send_t(17'h10000, 0);

		// A diagonal across the image, swept at the ends, midpoint and just inside/outside one.
		load_points(10'd0, 10'd0, 10'd300, 10'd900, 10'd700, 10'd100, 10'd1023, 10'd1023);
		send_t(17'h00000, 0);
		send_t(17'h00001, 1);
		send_t(17'h08000, 0);
		send_t(17'h0FFFF, 0);
		send_t(17'h10000, 3);
		send_t(17'h10001, 0);
		send_t(17'h15555, 0);
		send_t(17'h1FFFF, 0);
		send_t(17'h0AAAA, 0);
		send_t(17'h05555, 2);

		// Indices past the last register must be ignored, so the curve stays as it was.
		drain();
		write_reg(4'd8, 10'h3FF);
		write_reg(4'd15, 10'h155);
		cfg_valid <= 1'b0;
		send_t(17'h04000, 0);
		send_t(17'h0C000, 0);

		// Random control points, each phase a burst of random t with random gaps (phase 2 has none).
		for (int ph = 0; ph < 6; ph++) begin
			load_points(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
				pick_coord(), pick_coord(), pick_coord(), pick_coord());
			for (int n = 0; n < 34; n++) begin
				// Now and then hold off until the pipeline is empty.
				if ($urandom_range(0, 24) == 0)
					drain();
				send_t(pick_t(), (ph == 2) ? 0 : pick_gap());
			end
		end

		drain();
		repeat (30) @(posedge clk);
		$display("Covered %0d t beats over %0d control point sets, %0d pixel beats checked.",
			items_sent, phases + 1, results_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
sv/bzs_pkg.sv
sv/bzs_point.sv
sv/bzs_emit.sv
sv/bzs_cover.sv
sv/bezier_antialiased_splat_core.sv
tb/bzs_splat_checker.sv
tb/tb_bezier_antialiased_splat_core.sv
